// ===== hdl/evic_pkg.sv =====
// shared types and constants of the ethernet vlan / ip / l4 classifier
package evic_pkg;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_DROP  = 2'd1,
    VERDICT_ABORT = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    L3_NONE = 2'd0,
    L3_IPV4 = 2'd1,
    L3_IPV6 = 2'd2
  } l3_kind_e;

  typedef enum logic [1:0] {
    L4_NONE = 2'd0,
    L4_TCP  = 2'd1,
    L4_UDP  = 2'd2
  } l4_kind_e;

  localparam logic [15:0] EtVlanQ  = 16'h8100;
  localparam logic [15:0] EtVlanAd = 16'h88A8;
  localparam logic [15:0] EtIpv4   = 16'h0800;
  localparam logic [15:0] EtIpv6   = 16'h86DD;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  // header offsets and lengths, all below 128
  localparam logic [6:0] EthHdrLen     = 7'd14;
  localparam logic [6:0] TagLen        = 7'd4;
  localparam logic [6:0] EtHiOff       = 7'd12;
  localparam logic [6:0] EtLoOff       = 7'd13;
  localparam logic [6:0] InnerEtHiOff  = 7'd16;
  localparam logic [6:0] InnerEtLoOff  = 7'd17;
  localparam logic [6:0] Ipv4HdrLen    = 7'd20;
  localparam logic [6:0] Ipv6HdrLen    = 7'd40;
  localparam logic [6:0] Ipv4ProtoOff  = 7'd9;
  localparam logic [6:0] Ipv6NextOff   = 7'd6;
  localparam logic [6:0] PortHiOff     = 7'd2;
  localparam logic [6:0] PortLoOff     = 7'd3;
  localparam logic [6:0] TcpHdrLen     = 7'd20;
  localparam logic [6:0] UdpHdrLen     = 7'd8;

  function automatic l3_kind_e kind_of(input logic [15:0] et);
    l3_kind_e k;
    k = L3_NONE;
    if (et == EtIpv4) k = L3_IPV4;
    if (et == EtIpv6) k = L3_IPV6;
    return k;
  endfunction

endpackage

// ===== hdl/evic_if.sv =====
// valid/ready channel interfaces: frame bytes in, verdicts out, config write
interface evic_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface evic_out_if import evic_pkg::*; ();
  logic        valid;
  logic        ready;
  verdict_e    verdict;
  logic        vlan_seen;
  l3_kind_e    l3_kind;
  logic [7:0]  ip_protocol;
  logic        proto_count_valid;
  l4_kind_e    l4_kind;
  logic [15:0] dest_port;
  logic [15:0] frame_bytes;

  modport source (output valid, output verdict, output vlan_seen, output l3_kind,
                  output ip_protocol, output proto_count_valid, output l4_kind,
                  output dest_port, output frame_bytes, input ready);
  modport sink   (input valid, input verdict, input vlan_seen, input l3_kind,
                  input ip_protocol, input proto_count_valid, input l4_kind,
                  input dest_port, input frame_bytes, output ready);
endinterface

interface evic_cfg_if ();
  logic valid;
  logic ready;
  logic meta_space_ok;

  modport source (output valid, output meta_space_ok, input ready);
  modport sink   (input valid, input meta_space_ok, output ready);
endinterface

// ===== hdl/eth_vlan_ip_l4_classifier.sv =====
// ethernet frame classifier: vlan skip, ipv4/ipv6 protocol, tcp/udp destination port
//
// Frames enter one byte per beat on beat_in_i, last_byte marking the final byte.
// Exactly one result beat leaves on result_o for every frame, carrying the verdict
// (pass, drop or aborted), the keys found and the frame length, which saturates at
// 2^LENGTH_BITS-1. The block takes one byte every cycle with no gaps between frames:
// a byte is captured in an input register and then classified by a
// short compare/update step against the per-frame parse state, and the verdict sits
// in a result register, so a new byte is taken even while a verdict waits to be
// read. The result beat of a frame is valid once its verdict is in the result register.
// Back-pressure on result_o only stalls the input when a last byte is waiting for
// the result register. One 802.1Q or 802.1AD tag is skipped; ipv4 is read as a
// fixed 20-byte header (options ignored), ipv6 as a 40-byte header. Every header
// must fit inside the frame or the frame is dropped; an unknown ethertype aborts.
// Writing meta_space_ok = 0 on cfg_i turns every verdict into aborted; it resets
// to 1 and should only be written while no frame is in flight.
module eth_vlan_ip_l4_classifier import evic_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  evic_in_if.sink           beat_in_i,
  evic_out_if.source        result_o,
  evic_cfg_if.sink          cfg_i
);

  localparam logic [LENGTH_BITS-1:0] OffMax = '1;

  // config register
  logic meta_q;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // per-frame parse state
  logic [LENGTH_BITS-1:0] off_q, off_d;
  logic [15:0]            et_q, et_d;
  logic                   tag_q, tag_d;
  l3_kind_e               net_q, net_d;
  logic [7:0]             proto_q, proto_d;
  logic [15:0]            port_q, port_d;

  // result register
  logic        out_vld_q;
  verdict_e    verdict_q, verdict_d;
  logic        vseen_q, vseen_d;
  l3_kind_e    l3_q, l3_d;
  logic [7:0]  prot_q, prot_d;
  logic        pv_q, pv_d;
  l4_kind_e    l4_q, l4_d;
  logic [15:0] dport_q, dport_d;
  logic [15:0] len_q;

  logic                   out_free;
  logic                   proc;
  logic [LENGTH_BITS-1:0] pos;
  logic [LENGTH_BITS-1:0] len;
  logic [6:0]             base;
  logic [6:0]             l4base;
  logic [6:0]             need;

  // a non-last byte never needs the result register
  assign out_free = !out_vld_q || result_o.ready;
  assign proc     = in_vld_q && (!in_last_q || out_free);
  assign beat_in_i.ready = !in_vld_q || proc;
  assign cfg_i.ready     = 1'b1;

  assign pos = off_q;
  assign len = (off_q != OffMax) ? off_q + 1'b1 : off_q;

  // header walk for the byte held in the input register
  always_comb begin
    et_d    = et_q;
    tag_d   = tag_q;
    net_d   = net_q;
    proto_d = proto_q;
    port_d  = port_q;

    // outer ethertype
    if (pos == LENGTH_BITS'(EtHiOff)) et_d = {in_byte_q, 8'h00};
    if (pos == LENGTH_BITS'(EtLoOff)) begin
      et_d = {et_q[15:8], in_byte_q};
      if (et_d == EtVlanQ || et_d == EtVlanAd) tag_d = 1'b1;
      else net_d = kind_of(et_d);
    end
    // ethertype behind the tag
    if (tag_d && pos == LENGTH_BITS'(InnerEtHiOff)) et_d = {in_byte_q, 8'h00};
    if (tag_d && pos == LENGTH_BITS'(InnerEtLoOff)) begin
      et_d  = {et_q[15:8], in_byte_q};
      net_d = kind_of(et_d);
    end

    base   = tag_d ? EthHdrLen + TagLen : EthHdrLen;
    l4base = base + ((net_d == L3_IPV4) ? Ipv4HdrLen : Ipv6HdrLen);

    if (net_d == L3_IPV4 && pos == LENGTH_BITS'(base + Ipv4ProtoOff)) proto_d = in_byte_q;
    if (net_d == L3_IPV6 && pos == LENGTH_BITS'(base + Ipv6NextOff))  proto_d = in_byte_q;
    if (net_d != L3_NONE) begin
      if (pos == LENGTH_BITS'(l4base + PortHiOff)) port_d[15:8] = in_byte_q;
      if (pos == LENGTH_BITS'(l4base + PortLoOff)) port_d[7:0]  = in_byte_q;
    end

    off_d = len;
  end

  // verdict, evaluated on the frame's last byte
  always_comb begin
    verdict_d = VERDICT_PASS;
    vseen_d   = 1'b0;
    l3_d      = L3_NONE;
    prot_d    = 8'h00;
    pv_d      = 1'b0;
    l4_d      = L4_NONE;
    dport_d   = 16'h0000;
    need      = l4base + ((proto_d == ProtoTcp) ? TcpHdrLen : UdpHdrLen);

    priority if (!meta_q) begin
      verdict_d = VERDICT_ABORT;
    end else if (len < LENGTH_BITS'(EthHdrLen)) begin
      verdict_d = VERDICT_DROP;
    end else if (tag_d && len < LENGTH_BITS'(EthHdrLen + TagLen)) begin
      verdict_d = VERDICT_DROP;
    end else begin
      vseen_d = tag_d;
      if (net_d == L3_NONE) begin
        verdict_d = VERDICT_ABORT;
      end else begin
        l3_d = net_d;
        if (len < LENGTH_BITS'(l4base)) begin
          verdict_d = VERDICT_DROP;
        end else begin
          pv_d   = 1'b1;
          prot_d = proto_d;
          if (proto_d == ProtoTcp || proto_d == ProtoUdp) begin
            if (len < LENGTH_BITS'(need)) begin
              verdict_d = VERDICT_DROP;
            end else begin
              l4_d    = (proto_d == ProtoTcp) ? L4_TCP : L4_UDP;
              dport_d = port_d;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q    <= 1'b1;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      off_q     <= '0;
      et_q      <= '0;
      tag_q     <= 1'b0;
      net_q     <= L3_NONE;
      proto_q   <= '0;
      port_q    <= '0;
    end else begin
      if (cfg_i.valid) meta_q <= cfg_i.meta_space_ok;

      if (beat_in_i.valid && beat_in_i.ready) in_vld_q <= 1'b1;
      else if (proc)                          in_vld_q <= 1'b0;

      if (proc && in_last_q)   out_vld_q <= 1'b1;
      else if (result_o.ready) out_vld_q <= 1'b0;

      if (proc) begin
        if (in_last_q) begin
          // frame done, start the next one clean
          off_q   <= '0;
          et_q    <= '0;
          tag_q   <= 1'b0;
          net_q   <= L3_NONE;
          proto_q <= '0;
          port_q  <= '0;
        end else begin
          off_q   <= off_d;
          et_q    <= et_d;
          tag_q   <= tag_d;
          net_q   <= net_d;
          proto_q <= proto_d;
          port_q  <= port_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (beat_in_i.valid && beat_in_i.ready) begin
      in_byte_q <= beat_in_i.data_byte;
      in_last_q <= beat_in_i.last_byte;
    end
    if (proc && in_last_q) begin
      verdict_q <= verdict_d;
      vseen_q   <= vseen_d;
      l3_q      <= l3_d;
      prot_q    <= prot_d;
      pv_q      <= pv_d;
      l4_q      <= l4_d;
      dport_q   <= dport_d;
      len_q     <= 16'(len);
    end
  end

  assign result_o.valid             = out_vld_q;
  assign result_o.verdict           = verdict_q;
  assign result_o.vlan_seen         = vseen_q;
  assign result_o.l3_kind           = l3_q;
  assign result_o.ip_protocol       = prot_q;
  assign result_o.proto_count_valid = pv_q;
  assign result_o.l4_kind           = l4_q;
  assign result_o.dest_port         = dport_q;
  assign result_o.frame_bytes       = len_q;

  // offset restarts after every frame end
  a_off_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |=> (off_q == '0))
    else $error("byte offset not cleared after frame end");

  // a port key only comes with a passing frame whose ip header fit
  a_l4_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && l4_q != L4_NONE) |-> (verdict_q == VERDICT_PASS && pv_q))
    else $error("port key on a frame that did not pass");

  // a recognized ip ethertype never aborts
  a_l3_no_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && l3_q != L3_NONE) |-> (verdict_q != VERDICT_ABORT))
    else $error("abort verdict with known l3 kind");

  // a skipped tag means the tagged ethernet header was complete
  a_vlan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && vseen_q) |-> (len_q >= 16'(EthHdrLen + TagLen)))
    else $error("vlan seen on a frame too short for the tag");

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the ethernet vlan / ip / l4 classifier
`timescale 1ns / 1ps

module tb;
  import evic_pkg::*;

  localparam int LenBits    = 16;
  localparam int CycleLimit = 3_000_000;
  localparam int DrainCyc   = 6;

  // one verdict as it leaves the block
  typedef struct packed {
    verdict_e    verdict;
    logic        vlan_seen;
    l3_kind_e    l3_kind;
    logic [7:0]  ip_protocol;
    logic        proto_count_valid;
    l4_kind_e    l4_kind;
    logic [15:0] dest_port;
    logic [15:0] frame_bytes;
  } frame_res_t;

  // one directed frame: headers laid over fill bytes, optional typed verdict
  typedef struct packed {
    logic        meta;
    logic [15:0] tag_et;
    logic [15:0] eth_type;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [16:0] len;
    logic [8:0]  fill;
    logic        typed;
    frame_res_t  res;
  } frame_row_t;

  localparam logic [8:0] FillRnd  = 9'h100;
  localparam frame_res_t Untyped  = '0;

  // tag_et and eth_type both zero means raw bytes, no header laid over them
  localparam frame_row_t DirRows [22] = '{
    // first beat after reset is also the last: runt frame
    '{1'b1, 16'h0, 16'h0, 8'd0, 16'h0, 17'd1, 9'h000, 1'b1,
      '{VERDICT_DROP, 1'b0, L3_NONE, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd1}},
    '{1'b1, 16'h0, 16'h0, 8'd0, 16'h0, 17'd13, 9'h0FF, 1'b1,
      '{VERDICT_DROP, 1'b0, L3_NONE, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd13}},
    // unknown ethertype aborts
    '{1'b1, 16'h0, 16'h1234, 8'd0, 16'h0, 17'd14, 9'h000, 1'b1,
      '{VERDICT_ABORT, 1'b0, L3_NONE, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd14}},
    // ip header cut off
    '{1'b1, 16'h0, EtIpv4, ProtoTcp, 16'h0, 17'd14, FillRnd, 1'b1,
      '{VERDICT_DROP, 1'b0, L3_IPV4, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd14}},
    '{1'b1, 16'h0, EtIpv4, ProtoTcp, 16'h1234, 17'd33, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv4, 8'd1, 16'h0, 17'd34, FillRnd, 1'b0, Untyped},
    // tcp one byte short, then exactly fitting
    '{1'b1, 16'h0, EtIpv4, ProtoTcp, 16'hFFFF, 17'd53, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv4, ProtoTcp, 16'hFFFF, 17'd54, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv4, ProtoUdp, 16'h0000, 17'd41, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv4, ProtoUdp, 16'h8001, 17'd42, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv6, ProtoTcp, 16'h1F90, 17'd74, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv6, ProtoUdp, 16'h0035, 17'd61, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv6, ProtoUdp, 16'h0035, 17'd53, FillRnd, 1'b0, Untyped},
    // tag present but cut off before the inner ethertype ends
    '{1'b1, EtVlanQ, EtIpv4, ProtoUdp, 16'h0, 17'd17, FillRnd, 1'b1,
      '{VERDICT_DROP, 1'b0, L3_NONE, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd17}},
    '{1'b1, EtVlanQ, EtIpv4, ProtoUdp, 16'h4242, 17'd46, FillRnd, 1'b0, Untyped},
    '{1'b1, EtVlanAd, EtIpv6, ProtoTcp, 16'h01BB, 17'd78, FillRnd, 1'b0, Untyped},
    // double tag: inner ethertype is another tag, so unknown
    '{1'b1, EtVlanAd, EtVlanQ, 8'd0, 16'h0, 17'd18, FillRnd, 1'b1,
      '{VERDICT_ABORT, 1'b1, L3_NONE, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd18}},
    '{1'b1, EtVlanQ, EtIpv4, ProtoTcp, 16'h0, 17'd18, FillRnd, 1'b0, Untyped},
    // no metadata space: every frame aborts
    '{1'b0, 16'h0, EtIpv4, ProtoTcp, 16'h5555, 17'd60, FillRnd, 1'b1,
      '{VERDICT_ABORT, 1'b0, L3_NONE, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd60}},
    '{1'b0, 16'h0, 16'h0, 8'd0, 16'h0, 17'd1, FillRnd, 1'b1,
      '{VERDICT_ABORT, 1'b0, L3_NONE, 8'd0, 1'b0, L4_NONE, 16'd0, 16'd1}},
    '{1'b1, 16'h0, EtIpv6, 8'hFF, 16'h0, 17'd60, FillRnd, 1'b0, Untyped},
    '{1'b1, 16'h0, EtIpv4, ProtoTcp, 16'h7777, 17'd20, 9'h000, 1'b0, Untyped}
  };

  localparam logic PhaseMeta [4] = '{1'b1, 1'b0, 1'b1, 1'b1};

  logic clk;
  logic rst_n;

  evic_in_if  byte_if ();
  evic_out_if res_if ();
  evic_cfg_if cfg_if ();

  eth_vlan_ip_l4_classifier #(
    .LENGTH_BITS(LenBits)
  ) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .beat_in_i(byte_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #1 clk = ~clk;

  // parser mirror: per-frame state plus the one register
  logic        meta_ok;
  logic [15:0] parse_pos;
  logic [15:0] parse_et;
  logic        tag_skip;
  l3_kind_e    net_kind;
  logic [7:0]  proto_seen;
  logic [15:0] port_seen;

  frame_res_t  pending_verdicts[$];
  logic [7:0]  frame_buf[$];

  int miss_cnt;
  int result_cnt;
  int cycle_cnt;
  int burst_left;

  function automatic void clear_parse();
    parse_pos  = '0;
    parse_et   = '0;
    tag_skip   = 1'b0;
    net_kind   = L3_NONE;
    proto_seen = '0;
    port_seen  = '0;
  endfunction

  // advance the parse state by one byte; returns 1 with the verdict on a last byte
  function automatic bit classify_byte(input logic [7:0] b, input logic lst,
                                       output frame_res_t r);
    int pos, base, l4base, need, len;
    pos = parse_pos;
    r   = '0;
    if (pos == 12) parse_et = {b, 8'h00};
    if (pos == 13) begin
      parse_et[7:0] = b;
      if (parse_et == EtVlanQ || parse_et == EtVlanAd) begin
        tag_skip = 1'b1;
      end else begin
        net_kind = (parse_et == EtIpv4) ? L3_IPV4 : (parse_et == EtIpv6) ? L3_IPV6 : L3_NONE;
      end
    end
    if (tag_skip && pos == 16) parse_et = {b, 8'h00};
    if (tag_skip && pos == 17) begin
      parse_et[7:0] = b;
      net_kind = (parse_et == EtIpv4) ? L3_IPV4 : (parse_et == EtIpv6) ? L3_IPV6 : L3_NONE;
    end
    base   = tag_skip ? 18 : 14;
    l4base = base + ((net_kind == L3_IPV4) ? 20 : 40);
    if (net_kind == L3_IPV4 && pos == base + 9) proto_seen = b;
    if (net_kind == L3_IPV6 && pos == base + 6) proto_seen = b;
    if (net_kind != L3_NONE) begin
      if (pos == l4base + 2) port_seen[15:8] = b;
      if (pos == l4base + 3) port_seen[7:0] = b;
    end
    if (parse_pos != 16'((1 << LenBits) - 1)) parse_pos++;
    if (!lst) return 1'b0;

    len = parse_pos;
    r.frame_bytes = parse_pos;
    if (!meta_ok) begin
      r.verdict = VERDICT_ABORT;
    end else if (len < 14 || (tag_skip && len < 18)) begin
      r.verdict = VERDICT_DROP;
    end else begin
      r.vlan_seen = tag_skip;
      if (net_kind == L3_NONE) begin
        r.verdict = VERDICT_ABORT;
      end else begin
        r.l3_kind = net_kind;
        if (len < l4base) begin
          r.verdict = VERDICT_DROP;
        end else begin
          r.proto_count_valid = 1'b1;
          r.ip_protocol = proto_seen;
          if (proto_seen == ProtoTcp || proto_seen == ProtoUdp) begin
            need = l4base + ((proto_seen == ProtoTcp) ? 20 : 8);
            if (len < need) begin
              r.verdict = VERDICT_DROP;
            end else begin
              r.l4_kind   = (proto_seen == ProtoTcp) ? L4_TCP : L4_UDP;
              r.dest_port = port_seen;
            end
          end
        end
      end
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic void put_byte(input int idx, input logic [7:0] val);
    if (idx < frame_buf.size()) frame_buf[idx] = val;
  endfunction

  // lay ethernet, optional tag, ip and l4 port fields over fill bytes
  function automatic void make_frame(input logic [15:0] tag_et, input logic [15:0] eth_type,
                                     input logic [7:0] proto, input logic [15:0] port,
                                     input int len, input logic [8:0] fill);
    int base, l4base;
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      frame_buf.push_back(fill[8] ? 8'($urandom_range(0, 255)) : fill[7:0]);
    end
    if (tag_et == 16'h0 && eth_type == 16'h0) return;
    base = 14;
    if (tag_et != 16'h0) begin
      put_byte(12, tag_et[15:8]);
      put_byte(13, tag_et[7:0]);
      base = 18;
    end
    put_byte(base - 2, eth_type[15:8]);
    put_byte(base - 1, eth_type[7:0]);
    if (eth_type == EtIpv4) begin
      put_byte(base + 9, proto);
      l4base = base + 20;
    end else if (eth_type == EtIpv6) begin
      put_byte(base + 6, proto);
      l4base = base + 40;
    end else begin
      return;
    end
    put_byte(l4base + 2, port[15:8]);
    put_byte(l4base + 3, port[7:0]);
  endfunction

  // random frame, mostly well formed with lengths near the fit thresholds
  function automatic void rand_frame();
    logic [15:0] tag_et, eth_type;
    logic [7:0]  proto;
    logic [8:0]  fill;
    int          sel, l3end, l4end, len;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // pure noise
      make_frame(16'h0, 16'h0, 8'h0, 16'h0, $urandom_range(1, 80), FillRnd);
      return;
    end
    tag_et = 16'h0;
    if ($urandom_range(0, 2) == 0) tag_et = $urandom_range(0, 1) ? EtVlanQ : EtVlanAd;
    sel = $urandom_range(0, 19);
    if (sel < 8)       eth_type = EtIpv4;
    else if (sel < 15) eth_type = EtIpv6;
    else if (sel < 17) eth_type = 16'($urandom_range(0, 65535));
    else if (sel < 18) eth_type = EtVlanQ;
    else               eth_type = 16'h86DC;
    sel = $urandom_range(0, 19);
    if (sel < 8)       proto = ProtoTcp;
    else if (sel < 15) proto = ProtoUdp;
    else               proto = 8'($urandom_range(0, 255));
    l3end = ((tag_et != 16'h0) ? 18 : 14) + ((eth_type == EtIpv6) ? 40 : 20);
    l4end = l3end + ((proto == ProtoTcp) ? 20 : (proto == ProtoUdp) ? 8 : 0);
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      len = l4end + $urandom_range(0, 8);
    end else if (sel < 85) begin
      case ($urandom_range(0, 7))
        0: len = l4end - 1;
        1: len = l4end;
        2: len = l3end - 1;
        3: len = l3end;
        4: len = 13;
        5: len = 14;
        6: len = 17;
        default: len = 18;
      endcase
    end else begin
      len = $urandom_range(1, l4end + 16);
    end
    fill = FillRnd;
    if ($urandom_range(0, 15) == 0) fill = $urandom_range(0, 1) ? 9'h0FF : 9'h000;
    make_frame(tag_et, eth_type, proto, 16'($urandom_range(0, 65535)), len, fill);
  endfunction

  // offer one beat, with bursts and random gaps between them
  task automatic push_beat(input logic [7:0] b, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                : $urandom_range(1, 16);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.last_byte <= lst;
    @(posedge clk);
    while (byte_if.ready !== 1'b1) @(posedge clk);
    burst_left--;
  endtask

  // send frame_buf; a typed row replaces the mirror's verdict by its own
  task automatic send_frame(input logic typed, input frame_res_t typed_res);
    frame_res_t r;
    logic       lst;
    foreach (frame_buf[i]) begin
      lst = (i == frame_buf.size() - 1);
      push_beat(frame_buf[i], lst);
      if (classify_byte(frame_buf[i], lst, r)) begin
        pending_verdicts.push_back(typed ? typed_res : r);
      end
    end
  endtask

  // register write only with no frame in flight
  task automatic set_meta(input logic v);
    byte_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCyc) @(posedge clk);
    cfg_if.valid         <= 1'b1;
    cfg_if.meta_space_ok <= v;
    @(posedge clk);
    while (cfg_if.ready !== 1'b1) @(posedge clk);
    cfg_if.valid <= 1'b0;
    meta_ok    = v;
    burst_left = 0;
  endtask

  function automatic void check_field(input string field, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      miss_cnt++;
      if (miss_cnt <= 10) begin
        $display("verdict %0d: %s expected 0x%0h, got 0x%0h", result_cnt, field, want, got);
      end
    end
  endfunction

  // stimulus: directed rows, then random phases under both register values
  initial begin
    int phase_bytes, phase_frames;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    byte_if.valid        = 1'b0;
    byte_if.data_byte    = '0;
    byte_if.last_byte    = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.meta_space_ok = 1'b1;
    meta_ok              = 1'b1;
    miss_cnt             = 0;
    result_cnt           = 0;
    burst_left           = 0;
    clear_parse();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirRows[i]) begin
      if (DirRows[i].meta != meta_ok) set_meta(DirRows[i].meta);
      make_frame(DirRows[i].tag_et, DirRows[i].eth_type, DirRows[i].proto,
                 DirRows[i].port, int'(DirRows[i].len), DirRows[i].fill);
      send_frame(DirRows[i].typed, DirRows[i].res);
    end

    foreach (PhaseMeta[p]) begin
      set_meta(PhaseMeta[p]);
      phase_bytes  = 0;
      phase_frames = 0;
      while (phase_bytes < 180 || phase_frames < 9) begin
        rand_frame();
        phase_bytes += frame_buf.size();
        phase_frames++;
        send_frame(1'b0, Untyped);
      end
    end

    byte_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (miss_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // verdict side back-pressure: short stalls, with calm stretches of no stall
  initial begin
    int stall_left, calm_left, pick;
    res_if.ready = 1'b0;
    stall_left   = 0;
    calm_left    = 0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) begin
        calm_left--;
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        pick = $urandom_range(0, 15);
        if (pick == 0) calm_left = $urandom_range(50, 300);
        else if (pick < 4) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // compare every accepted verdict beat with the oldest pending one
  always @(posedge clk) begin : check_verdicts
    frame_res_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        miss_cnt++;
        if (miss_cnt <= 10) begin
          $display("verdict %0d: unexpected beat, verdict %0d bytes %0d", result_cnt,
                   res_if.verdict, res_if.frame_bytes);
        end
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 16'(want.verdict), 16'(res_if.verdict));
        check_field("vlan_seen", 16'(want.vlan_seen), 16'(res_if.vlan_seen));
        check_field("l3_kind", 16'(want.l3_kind), 16'(res_if.l3_kind));
        check_field("ip_protocol", 16'(want.ip_protocol), 16'(res_if.ip_protocol));
        check_field("proto_count_valid", 16'(want.proto_count_valid),
                    16'(res_if.proto_count_valid));
        check_field("l4_kind", 16'(want.l4_kind), 16'(res_if.l4_kind));
        check_field("dest_port", want.dest_port, res_if.dest_port);
        check_field("frame_bytes", want.frame_bytes, res_if.frame_bytes);
      end
      result_cnt++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
